FILE: rtl/core/priority_ternary_match_table_assert.svh
// assertion macros of the match table rtl
`ifndef PRIORITY_TERNARY_MATCH_TABLE_ASSERT_SVH
`define PRIORITY_TERNARY_MATCH_TABLE_ASSERT_SVH

// checked only while out of reset
`define PTMT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define PTMT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/ptmt_pkg.sv
// types and constants of the priority ternary match table
package ptmt_pkg;

  localparam int FIELD_W     = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int IN_TDATA_W  = 5 * FIELD_W;
  localparam int OUT_TDATA_W = 40;
  localparam int STATUS_W    = 2;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_ERASE  = 2'd1,
    FN_LOOKUP = 2'd2,
    FN_NOP    = 2'd3
  } ptmt_func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MASKERR  = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } ptmt_status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_WRITE,
    S_DONE
  } ptmt_state_t;

endpackage

FILE: rtl/core/ptmt_ram.sv
// generic simple dual-port ram with registered read
module ptmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/priority_ternary_match_table.sv
// top level of the priority ternary match table
//
// one request per in_ transfer: in_tuser carries the operation (insert, erase,
// lookup, no-op), in_tdata the entry fields and the lookup key
// one result per request on the out_ channel: status, hit flag, found payload
// all entries live in one ram; a sequencer reads one slot per cycle through
// its single read port and a shared comparator evaluates it against the
// request (free slot for insert, exact match for erase, ternary match with
// best rank for lookup), then a write cycle updates the slot if needed
// insert, erase and lookup scan every slot (S_SCAN, S_LAST) before the result; an
// insert or erase that finds its slot writes it in S_WRITE first; a masking error
// or a no-op skips the scan and goes straight to S_DONE
// a new request is taken only in S_IDLE, after the last result has left S_DONE
// at reset the ram is swept once to clear every slot, with in_tready low
// the result sits in an output register; a new request is taken while it
// waits, and a finished result waits in the sequencer until out_tready frees
// the output register
module priority_ternary_match_table #(
  parameter int KEY_BITS     = 32,
  parameter int TABLE_DEPTH  = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // func[1:0]
  input  logic [ptmt_pkg::IN_TUSER_W-1:0]  in_tuser,
  // pattern[31:0], care_mask[63:32], rank[95:64], payload[127:96],
  // search_key[159:128]
  input  logic [ptmt_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status[1:0], hit[2], found_payload[34:3], zero fill[39:35]
  output logic [ptmt_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import ptmt_pkg::*;

  `include "priority_ternary_match_table_assert.svh"

  // stored widths: fields arrive 32 bits wide and are cut to the parameters
  localparam int KW       = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
  localparam int PW       = (PAYLOAD_BITS < FIELD_W) ? PAYLOAD_BITS : FIELD_W;
  localparam int AW       = $clog2(TABLE_DEPTH);
  localparam int WORD_W   = 1 + 2 * KW + FIELD_W + PW;
  localparam int PAD_W    = OUT_TDATA_W - STATUS_W - 1 - FIELD_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

  // sequencer state
  ptmt_state_t state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_idx_r, pend_idx_nxt;

  // latched request
  ptmt_func_t    func_r, func_nxt;
  logic [KW-1:0] pat_r, pat_nxt;
  logic [KW-1:0] mask_r, mask_nxt;
  logic [FIELD_W-1:0] rank_r, rank_nxt;
  logic [PW-1:0] pay_r, pay_nxt;
  logic [KW-1:0] key_r, key_nxt;

  // scan results
  logic          found_r, found_nxt;
  logic [AW-1:0] sel_idx_r, sel_idx_nxt;
  logic [FIELD_W-1:0] best_rank_r, best_rank_nxt;
  logic [PW-1:0] best_pay_r, best_pay_nxt;

  // finished result waiting for the output register
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                res_hit_r, res_hit_nxt;
  logic [FIELD_W-1:0]  res_pay_r, res_pay_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_hit_r, out_hit_nxt;
  logic [FIELD_W-1:0]  out_pay_r, out_pay_nxt;

  // ram port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [WORD_W-1:0] ram_rdata;

  // incoming fields, cut to stored widths
  logic [KW-1:0]      in_pat;
  logic [KW-1:0]      in_mask;
  logic [FIELD_W-1:0] in_rank;
  logic [PW-1:0]      in_pay;
  logic [KW-1:0]      in_key;
  logic               in_mask_err;

  // slot read back from the ram
  logic               slot_valid;
  logic [KW-1:0]      slot_pat;
  logic [KW-1:0]      slot_mask;
  logic [FIELD_W-1:0] slot_rank;
  logic [PW-1:0]      slot_pay;
  logic               slot_exact;
  logic               slot_tmatch;

  assign in_pat      = in_tdata[0 +: KW];
  assign in_mask     = in_tdata[FIELD_W +: KW];
  assign in_rank     = in_tdata[2 * FIELD_W +: FIELD_W];
  assign in_pay      = in_tdata[3 * FIELD_W +: PW];
  assign in_key      = in_tdata[4 * FIELD_W +: KW];
  // data one under a don't-care bit can never be stored
  assign in_mask_err = |(in_pat & ~in_mask);

  assign slot_pay   = ram_rdata[0 +: PW];
  assign slot_rank  = ram_rdata[PW +: FIELD_W];
  assign slot_mask  = ram_rdata[PW + FIELD_W +: KW];
  assign slot_pat   = ram_rdata[PW + FIELD_W + KW +: KW];
  assign slot_valid = ram_rdata[WORD_W-1];

  // shared comparator: one slot per cycle against the latched request
  assign slot_exact  = slot_valid && (slot_pat == pat_r) && (slot_mask == mask_r) &&
                       (slot_rank == rank_r) && (slot_pay == pay_r);
  assign slot_tmatch = slot_valid && (((key_r ^ slot_pat) & slot_mask) == '0);

  ptmt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {PAD_W'(0), out_pay_r, out_hit_r, out_status_r};

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    func_nxt       = func_r;
    pat_nxt        = pat_r;
    mask_nxt       = mask_r;
    rank_nxt       = rank_r;
    pay_nxt        = pay_r;
    key_nxt        = key_r;
    found_nxt      = found_r;
    sel_idx_nxt    = sel_idx_r;
    best_rank_nxt  = best_rank_r;
    best_pay_nxt   = best_pay_r;
    res_status_nxt = res_status_r;
    res_hit_nxt    = res_hit_r;
    res_pay_nxt    = res_pay_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_hit_nxt    = out_hit_r;
    out_pay_nxt    = out_pay_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = '0;
    ram_re         = 1'b0;

    // evaluate the slot read in the previous cycle
    if (pend_r) begin
      case (func_r)
        FN_INSERT: begin
          if (!slot_valid && !found_r) begin
            found_nxt   = 1'b1;
            sel_idx_nxt = pend_idx_r;
          end
        end
        FN_ERASE: begin
          if (slot_exact && !found_r) begin
            found_nxt   = 1'b1;
            sel_idx_nxt = pend_idx_r;
          end
        end
        FN_LOOKUP: begin
          // strict compare keeps the lowest slot on equal rank
          if (slot_tmatch && (!found_r || (slot_rank > best_rank_r))) begin
            found_nxt     = 1'b1;
            best_rank_nxt = slot_rank;
            best_pay_nxt  = slot_pay;
          end
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          func_nxt       = ptmt_func_t'(in_tuser);
          pat_nxt        = in_pat;
          mask_nxt       = in_mask;
          rank_nxt       = in_rank;
          pay_nxt        = in_pay;
          key_nxt        = in_key;
          found_nxt      = 1'b0;
          idx_nxt        = '0;
          res_status_nxt = ST_OK;
          res_hit_nxt    = 1'b0;
          res_pay_nxt    = '0;
          case (ptmt_func_t'(in_tuser))
            FN_INSERT: begin
              if (in_mask_err) begin
                res_status_nxt = ST_MASKERR;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            FN_ERASE:  state_nxt = S_SCAN;
            FN_LOOKUP: state_nxt = S_SCAN;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        ram_re       = 1'b1;
        pend_nxt     = 1'b1;
        pend_idx_nxt = idx_r;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_LAST;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_LAST: begin
        // the last slot is evaluated this cycle, so decide on the next values
        case (func_r)
          FN_INSERT: begin
            if (found_nxt) begin
              state_nxt = S_WRITE;
            end else begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_DONE;
            end
          end
          FN_ERASE: begin
            if (found_nxt) begin
              state_nxt = S_WRITE;
            end else begin
              res_status_nxt = ST_NOTFOUND;
              state_nxt      = S_DONE;
            end
          end
          default: begin
            res_status_nxt = ST_OK;
            res_hit_nxt    = found_nxt;
            res_pay_nxt    = found_nxt ? FIELD_W'(best_pay_nxt) : '0;
            state_nxt      = S_DONE;
          end
        endcase
      end
      S_WRITE: begin
        // insert fills the chosen slot, erase clears its valid bit
        ram_we         = 1'b1;
        ram_waddr      = sel_idx_r;
        ram_wdata      = {func_r == FN_INSERT, pat_r, mask_r, rank_r, pay_r};
        res_status_nxt = ST_OK;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_hit_nxt    = res_hit_r;
          out_pay_nxt    = res_pay_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_idx_r   <= pend_idx_nxt;
    func_r       <= func_nxt;
    pat_r        <= pat_nxt;
    mask_r       <= mask_nxt;
    rank_r       <= rank_nxt;
    pay_r        <= pay_nxt;
    key_r        <= key_nxt;
    sel_idx_r    <= sel_idx_nxt;
    best_rank_r  <= best_rank_nxt;
    best_pay_r   <= best_pay_nxt;
    res_status_r <= res_status_nxt;
    res_hit_r    <= res_hit_nxt;
    res_pay_r    <= res_pay_nxt;
    out_status_r <= out_status_nxt;
    out_hit_r    <= out_hit_nxt;
    out_pay_r    <= out_pay_nxt;
  end

  // reset always starts the clearing sweep
  `PTMT_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> (state_r == S_CLEAR), "reset did not start clear")
  // a slot is written back only after the scan picked one
  `PTMT_ASSERT(a_write_found, (state_r == S_WRITE) |-> found_r, "write without selected slot")
  // a hit only comes with an ok status
  `PTMT_ASSERT(a_hit_ok, (out_valid_r && out_hit_r) |-> (out_status_r == ST_OK), "hit with error status")
  // no hit means a zero payload
  `PTMT_ASSERT(a_miss_zero, (out_valid_r && !out_hit_r) |-> (out_pay_r == '0), "payload on miss")
  // compare stage only follows a scan read
  `PTMT_ASSERT(a_pend_scan, pend_r |-> ($past(state_r) == S_SCAN), "compare without read")

endmodule

FILE: bench/priority_ternary_match_table_checker.sv
// result checker of the priority ternary match table: shadow table, expected results, compare
`timescale 1ns / 100ps
module priority_ternary_match_table_checker
  import ptmt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     fail_count,
  output int                     results_pending
);

  typedef struct packed {
    ptmt_status_t       status;
    logic               hit;
    logic [FIELD_W-1:0] found_payload;
  } match_result_t;

  // shadow copy of the table
  logic               held [TABLE_DEPTH];
  logic [FIELD_W-1:0] held_pattern [TABLE_DEPTH];
  logic [FIELD_W-1:0] held_mask [TABLE_DEPTH];
  logic [FIELD_W-1:0] held_rank [TABLE_DEPTH];
  logic [FIELD_W-1:0] held_payload [TABLE_DEPTH];

  match_result_t awaited_results[$];

  // applies one request to the shadow table and returns the result it must give
  function automatic match_result_t apply_request(ptmt_func_t op, logic [FIELD_W-1:0] pat,
                                                  logic [FIELD_W-1:0] msk,
                                                  logic [FIELD_W-1:0] rnk,
                                                  logic [FIELD_W-1:0] pay,
                                                  logic [FIELD_W-1:0] key);
    match_result_t      res;
    logic               done;
    logic [FIELD_W-1:0] best_rank;
    int                 s;
    res.status        = ST_OK;
    res.hit           = 1'b0;
    res.found_payload = '0;
    done              = 1'b0;
    best_rank         = '0;
    case (op)
      FN_INSERT: begin
        if ((pat & ~msk) != '0) begin
          res.status = ST_MASKERR;
        end else begin
          for (s = 0; s < TABLE_DEPTH; s++) begin
            if (!done && !held[s]) begin
              held[s]         = 1'b1;
              held_pattern[s] = pat;
              held_mask[s]    = msk;
              held_rank[s]    = rnk;
              held_payload[s] = pay;
              done            = 1'b1;
            end
          end
          if (!done) res.status = ST_FULL;
        end
      end
      FN_ERASE: begin
        for (s = 0; s < TABLE_DEPTH; s++) begin
          if (!done && held[s] && held_pattern[s] == pat && held_mask[s] == msk &&
              held_rank[s] == rnk && held_payload[s] == pay) begin
            held[s] = 1'b0;
            done    = 1'b1;
          end
        end
        if (!done) res.status = ST_NOTFOUND;
      end
      FN_LOOKUP: begin
        // strict greater-than keeps the lowest slot on equal rank
        for (s = 0; s < TABLE_DEPTH; s++) begin
          if (held[s] && ((key ^ held_pattern[s]) & held_mask[s]) == '0 &&
              (!res.hit || held_rank[s] > best_rank)) begin
            res.hit           = 1'b1;
            best_rank         = held_rank[s];
            res.found_payload = held_payload[s];
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    match_result_t seen;
    match_result_t want;
    int            errs;
    errs = 0;
    if (!rst_n) begin
      for (int s = 0; s < TABLE_DEPTH; s++) held[s] = 1'b0;
      awaited_results.delete();
      fail_count      <= 0;
      results_pending <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen.status        = ptmt_status_t'(out_tdata[STATUS_W-1:0]);
        seen.hit           = out_tdata[STATUS_W];
        seen.found_payload = out_tdata[STATUS_W+1 +: FIELD_W];
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing expected: status %0d hit %0d payload %h",
                 seen.status, seen.hit, seen.found_payload);
          errs++;
        end else begin
          want = awaited_results.pop_front();
          if (seen.status != want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, seen.status);
            errs++;
          end
          if (seen.hit != want.hit) begin
            $error("hit mismatch: expected %0d, actual %0d", want.hit, seen.hit);
            errs++;
          end
          if (seen.found_payload != want.found_payload) begin
            $error("found_payload mismatch: expected %h, actual %h",
                   want.found_payload, seen.found_payload);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        awaited_results.insert(awaited_results.size(),
                               apply_request(ptmt_func_t'(in_tuser),
                                             in_tdata[0*FIELD_W +: FIELD_W],
                                             in_tdata[1*FIELD_W +: FIELD_W],
                                             in_tdata[2*FIELD_W +: FIELD_W],
                                             in_tdata[3*FIELD_W +: FIELD_W],
                                             in_tdata[4*FIELD_W +: FIELD_W]));
      end
      fail_count      <= fail_count + errs;
      results_pending <= awaited_results.size();
    end
  end

endmodule

FILE: bench/priority_ternary_match_table_tb.sv
// testbench top of the priority ternary match table: requests, sink pacing and verdict
`timescale 1ns / 100ps
module priority_ternary_match_table_tb;
  import ptmt_pkg::*;

  localparam int TABLE_DEPTH   = 64;
  localparam int RANDOM_ITEMS  = 1100;
  // one long sink hold-off, well inside the random part, to back the block up
  localparam int LONG_HOLD_AT  = 6000;
  localparam int LONG_HOLD_LEN = 800;
  // a full scan plus the write cycle, with margin
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 40;

  typedef struct {
    logic [FIELD_W-1:0] pattern;
    logic [FIELD_W-1:0] care_mask;
    logic [FIELD_W-1:0] rank;
    logic [FIELD_W-1:0] payload;
  } entry_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // func[1:0]
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  // pattern[31:0], care_mask[63:32], rank[95:64], payload[127:96], search_key[159:128]
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // status[1:0], hit[2], found_payload[34:3], zero fill[39:35]
  logic [OUT_TDATA_W-1:0] out_tdata;

  int fail_count;
  int results_pending;

  // entries believed to be in the table, used to build well-formed erases and hitting keys;
  // an insert refused for a full table still lands here, so some erases miss
  entry_t stored_guess[$];
  int     burst_left = 0;

  priority_ternary_match_table #(
    .KEY_BITS    (32),
    .TABLE_DEPTH (TABLE_DEPTH),
    .PAYLOAD_BITS(32)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  priority_ternary_match_table_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tuser       (in_tuser),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .fail_count     (fail_count),
    .results_pending(results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // care masks of several shapes: exact, wildcard, sparse, dense, prefix style, plain random
  function automatic logic [FIELD_W-1:0] random_mask();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      2: return $urandom & $urandom & $urandom;
      3: return $urandom | $urandom;
      4: return 32'hFFFF_FFFF << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // small ranks give plenty of ties, extremes test the unsigned compare
  function automatic logic [FIELD_W-1:0] random_rank();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // offers one request and holds it until the transfer; the sender runs in bursts
  // of random length with random idle gaps between them
  task automatic send_request(input ptmt_func_t op, input logic [FIELD_W-1:0] pat,
                              input logic [FIELD_W-1:0] msk, input logic [FIELD_W-1:0] rnk,
                              input logic [FIELD_W-1:0] pay, input logic [FIELD_W-1:0] key);
    int     gap;
    entry_t guess;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {key, pay, rnk, msk, pat};
    do @(posedge clk); while (!in_tready);
    if (op == FN_INSERT && (pat & ~msk) == '0 && stored_guess.size() < 2 * TABLE_DEPTH) begin
      guess.pattern   = pat;
      guess.care_mask = msk;
      guess.rank      = rnk;
      guess.payload   = pay;
      stored_guess.insert(stored_guess.size(), guess);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // gaps up to beyond one scan so that idling lands on every phase of the work
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(1, 90);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 5);
    end
  endtask

  // one random request; the weights set how far the table is filled or drained
  task automatic send_random_request(input int insert_w, input int erase_w);
    int          roll;
    int          idx;
    int          bit_no;
    entry_t      e;
    logic [FIELD_W-1:0] pat, msk, rnk, pay, key;
    roll = $urandom_range(0, 99);
    pat  = $urandom;
    msk  = random_mask();
    rnk  = random_rank();
    pay  = $urandom;
    key  = $urandom;
    if (roll < insert_w) begin
      // mostly well-formed entries, now and then data bits outside the care mask
      if ($urandom_range(0, 9) != 0) pat = pat & msk;
      send_request(FN_INSERT, pat, msk, rnk, pay, key);
    end else if (roll < insert_w + erase_w) begin
      if (stored_guess.size() > 0 && $urandom_range(0, 9) < 8) begin
        idx = $urandom_range(0, stored_guess.size() - 1);
        e   = stored_guess[idx];
        pat = e.pattern;
        msk = e.care_mask;
        rnk = e.rank;
        pay = e.payload;
        if ($urandom_range(0, 7) == 0) begin
          // near miss: one bit off in one field, normally not found
          bit_no = $urandom_range(0, FIELD_W - 1);
          case ($urandom_range(0, 3))
            0: pat[bit_no] = ~pat[bit_no];
            1: msk[bit_no] = ~msk[bit_no];
            2: rnk[bit_no] = ~rnk[bit_no];
            default: pay[bit_no] = ~pay[bit_no];
          endcase
        end else begin
          stored_guess.delete(idx);
        end
      end
      send_request(FN_ERASE, pat, msk, rnk, pay, key);
    end else if (roll < 97) begin
      // most keys are built to hit a stored entry, don't-care bits random
      if (stored_guess.size() > 0 && $urandom_range(0, 3) != 0) begin
        e   = stored_guess[$urandom_range(0, stored_guess.size() - 1)];
        key = (e.pattern & e.care_mask) | (key & ~e.care_mask);
      end
      send_request(FN_LOOKUP, pat, msk, rnk, pay, key);
    end else begin
      send_request(FN_NOP, pat, msk, rnk, pay, key);
    end
  endtask

  initial begin : request_source
    int sent;
    int phase_no;
    int phase_len;
    sent     = 0;
    phase_no = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed part; the block clears its table first, the handshake waits for that
    send_request(FN_LOOKUP, '0, '0, '0, '0, '0);               // lookup on an empty table
    send_request(FN_ERASE,  '0, '0, '0, '0, '0);               // erase on an empty table
    send_request(FN_NOP,    '1, '1, '1, '1, '1);               // unused operation
    send_request(FN_INSERT, 32'h1, '0, '0, '0, '0);            // data bit where mask is zero
    send_request(FN_INSERT, '1, '1, '0, '1, '1);               // exact all-ones entry
    send_request(FN_INSERT, '0, '0, '0, '0, '1);               // full wildcard, rank zero
    send_request(FN_LOOKUP, '0, '0, '0, '0, '1);               // rank tie, lowest slot wins
    send_request(FN_LOOKUP, '1, '1, '1, '1, '0);               // wildcard hit with zero payload
    send_request(FN_INSERT, 32'hA0, 32'hF0, 32'd5, 32'h1234_5678, '0);
    send_request(FN_LOOKUP, '0, '0, '0, '0, 32'h1234_56A7);    // higher rank wins
    send_request(FN_INSERT, 32'hA0, 32'hF0, 32'd5, 32'h1234_5678, '0);  // duplicate insert
    send_request(FN_INSERT, '0, '0, '1, 32'h8000_0001, '0);    // wildcard at the top rank
    send_request(FN_LOOKUP, '0, '0, '0, '0, 32'hA0);
    send_request(FN_ERASE,  32'hA0, 32'hF0, 32'd5, 32'h1234_5678, '0);  // frees one twin only
    send_request(FN_ERASE,  '0, '0, '1, 32'h8000_0001, '0);
    send_request(FN_LOOKUP, '0, '0, '0, '0, 32'hA5);           // the remaining twin answers
    send_request(FN_ERASE,  32'h1, '0, '0, '0, '0);            // pair no insert could store
    send_request(FN_ERASE,  32'hA0, 32'hF0, 32'd5, 32'h1234_5679, '0);  // payload differs
    send_request(FN_INSERT, 32'h5500, 32'hFF00, 32'd5, 32'h42, '0);     // takes the freed slot
    send_request(FN_LOOKUP, '0, '0, '0, '0, 32'h55A0);         // equal ranks, lower slot
    send_request(FN_ERASE,  '0, '0, '0, '0, '0);               // remove the wildcard
    send_request(FN_LOOKUP, '0, '0, '0, '0, '0);               // no match left
    send_request(FN_INSERT, '1, 32'h7FFF_FFFF, '1, '1, '1);    // top data bit not cared
    send_request(FN_NOP, $urandom, $urandom, $urandom, $urandom, $urandom);

    // random part in phases that fill, mix and drain the table
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(60, 160);
      for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
        case (phase_no % 3)
          0: send_random_request(70, 10);
          1: send_random_request(35, 30);
          default: send_random_request(10, 60);
        endcase
        sent++;
      end
      phase_no++;
    end
    in_tvalid <= 1'b0;

    // let the checker see the last transfer before asking what is still open
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("priority_ternary_match_table_tb passed");
    end else begin
      $display("priority_ternary_match_table_tb failed");
    end
    $finish;
  end

  // sink pacing: modes of random length, plus one long hold-off counted here
  initial begin : sink_pacing
    int cycle_no;
    int mode;
    int mode_left;
    int hold_left;
    cycle_no  = 0;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      cycle_no++;
      if (cycle_no == LONG_HOLD_AT) hold_left = LONG_HOLD_LEN;
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0: out_tready <= 1'b1;                              // always ready
          1: out_tready <= ($urandom_range(0, 1) == 0);       // coin toss
          2: out_tready <= ($urandom_range(0, 3) == 0);       // mostly stalled
          default: out_tready <= cycle_no[0];                 // alternate cycles
        endcase
      end
    end
  end

  // overall time limit
  initial begin
    #8_000_000;
    $display("priority_ternary_match_table_tb failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/ptmt_pkg.sv
rtl/core/ptmt_ram.sv
rtl/core/priority_ternary_match_table.sv
bench/priority_ternary_match_table_checker.sv
bench/priority_ternary_match_table_tb.sv
